// ===== rtl/flvtd_pkg.sv =====
// Shared types and constants for the FLV tag deframer.
package flvtd_pkg;

	localparam logic [31:0] SIGNATURE    = 32'h464C_5601;
	localparam logic [7:0]  AV_MASK      = 8'h05;
	localparam logic [31:0] FILE_HDR_LEN = 32'd9;
	localparam logic [31:0] TAG_HDR_LEN  = 32'd11;
	localparam logic [31:0] SIZE_LEN     = 32'd4;
	localparam logic [23:0] PAYLOAD_MASK = 24'hFF_FFFF;

	localparam logic [1:0] WARN_NONE     = 2'd0;
	localparam logic [1:0] WARN_NO_AV    = 2'd1;
	localparam logic [1:0] WARN_OFFSET   = 2'd2;
	localparam logic [1:0] WARN_FIRST_SZ = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_BAD_SIG   = 3'd1;
	localparam logic [2:0] ST_LOW_OFFS  = 3'd2;
	localparam logic [2:0] ST_FOOTER    = 3'd3;
	localparam logic [2:0] ST_TRUNCATED = 3'd4;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       stream_end;
	} flv_in_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        in_tag;
		logic        tag_first;
		logic        tag_last;
		logic [7:0]  tag_type;
		logic [23:0] payload_size;
		logic [31:0] tag_timestamp;
		logic [1:0]  warning;
		logic [2:0]  status;
		logic        halted;
	} flv_out_t;

endpackage

// ===== rtl/flv_tag_deframer.sv =====
// FLV tag deframer: byte-wide stream parser with tag framing marks.
//
// in_data carries one stream byte per transaction plus a stream_end flag.
// Every accepted byte yields exactly one out_data transaction echoing the
// byte with in_tag/tag_first/tag_last marks, the current tag's type, size
// and timestamp, a two-bit warning code and the sticky status code.
// The result sits in the output register on the cycle after acceptance.
// Throughput is one byte per cycle while the receiver does not stall; all framing
// state is updated by a single pass of logic (one 32-bit add/compare on
// the byte counter) between the state registers and the output register.
// A new byte is taken whenever the output register is empty or is being
// drained in the same cycle, so a stalled receiver holds in_ready low and
// the pending result stays unchanged.
// Reset returns the parser to the file header phase with all counters and
// captured fields at zero. A fatal error (bad signature, offset below
// nine, footer mismatch, truncation) halts framing until reset; bytes are
// still echoed. A stream ending cleanly on the first size word or a tag's
// last footer byte returns the parser to its reset state for a new stream.
module flv_tag_deframer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  flvtd_pkg::flv_in_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output flvtd_pkg::flv_out_t out_data
);

	typedef enum logic [2:0] {
		PH_FILE_HDR,
		PH_SKIP,
		PH_FIRST,
		PH_TAG_HDR,
		PH_PAYLOAD,
		PH_FOOTER,
		PH_HALT
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] byte_count_q, byte_count_d;
	logic [31:0] data_offset_q, data_offset_d;
	logic [23:0] payload_len_q, payload_len_d;
	logic [31:0] footer_value_q, footer_value_d;
	logic [7:0]  tag_kind_q, tag_kind_d;
	logic [31:0] tag_time_q, tag_time_d;
	logic [2:0]  err_code_q, err_code_d;

	flvtd_pkg::flv_out_t out_q, out_d;
	logic                out_valid_q;
	logic                accept;
	logic                restart;

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		logic [7:0]  b;
		logic        intag;
		logic        first;
		logic        last;
		logic [1:0]  warn;
		logic        boundary;
		logic        fatal;
		logic [31:0] cnt_inc;

		b        = in_data.data_byte;
		intag    = 1'b0;
		first    = 1'b0;
		last     = 1'b0;
		warn     = flvtd_pkg::WARN_NONE;
		boundary = 1'b0;
		fatal    = 1'b0;
		cnt_inc  = byte_count_q + 32'd1;

		phase_d        = phase_q;
		byte_count_d   = byte_count_q;
		data_offset_d  = data_offset_q;
		payload_len_d  = payload_len_q;
		footer_value_d = footer_value_q;
		tag_kind_d     = tag_kind_q;
		tag_time_d     = tag_time_q;
		err_code_d     = err_code_q;

		case (phase_q)
			PH_HALT: begin
			end
			PH_FILE_HDR: begin
				if (byte_count_q < 32'd4) begin
					footer_value_d = {footer_value_q[23:0], b};
					if (byte_count_q == 32'd3 && footer_value_d != flvtd_pkg::SIGNATURE) begin
						fatal      = 1'b1;
						err_code_d = flvtd_pkg::ST_BAD_SIG;
					end
				end else if (byte_count_q == 32'd4) begin
					if ((b & flvtd_pkg::AV_MASK) == 8'd0)
						warn = flvtd_pkg::WARN_NO_AV;
				end else begin
					data_offset_d = {data_offset_q[23:0], b};
				end
				if (!fatal) begin
					if (byte_count_q >= flvtd_pkg::FILE_HDR_LEN - 32'd1) begin
						byte_count_d = '0;
						if (data_offset_d < flvtd_pkg::FILE_HDR_LEN) begin
							fatal      = 1'b1;
							err_code_d = flvtd_pkg::ST_LOW_OFFS;
						end else begin
							if (data_offset_d != flvtd_pkg::FILE_HDR_LEN)
								warn = flvtd_pkg::WARN_OFFSET;
							phase_d = (data_offset_d > flvtd_pkg::FILE_HDR_LEN) ?
								PH_SKIP : PH_FIRST;
						end
					end else begin
						byte_count_d = cnt_inc;
					end
				end
			end
			PH_SKIP: begin
				byte_count_d = cnt_inc;
				if (cnt_inc >= data_offset_q - flvtd_pkg::FILE_HDR_LEN) begin
					byte_count_d = '0;
					phase_d      = PH_FIRST;
				end
			end
			PH_FIRST: begin
				footer_value_d = {footer_value_q[23:0], b};
				if (byte_count_q >= flvtd_pkg::SIZE_LEN - 32'd1) begin
					if (footer_value_d != 32'd0)
						warn = flvtd_pkg::WARN_FIRST_SZ;
					byte_count_d = '0;
					phase_d      = PH_TAG_HDR;
					boundary     = 1'b1;
				end else begin
					byte_count_d = cnt_inc;
				end
			end
			PH_TAG_HDR: begin
				intag = 1'b1;
				if (byte_count_q == 32'd0) begin
					first         = 1'b1;
					tag_kind_d    = b;
					payload_len_d = '0;
					tag_time_d    = '0;
				end else if (byte_count_q <= 32'd3) begin
					payload_len_d = {payload_len_q[15:0], b} & flvtd_pkg::PAYLOAD_MASK;
				end else if (byte_count_q <= 32'd6) begin
					tag_time_d = {tag_time_q[31:24], tag_time_q[15:0], b};
				end else if (byte_count_q == 32'd7) begin
					tag_time_d = {b, tag_time_q[23:0]};
				end
				if (byte_count_q >= flvtd_pkg::TAG_HDR_LEN - 32'd1) begin
					byte_count_d = '0;
					phase_d      = (payload_len_d != 24'd0) ? PH_PAYLOAD : PH_FOOTER;
				end else begin
					byte_count_d = cnt_inc;
				end
			end
			PH_PAYLOAD: begin
				intag        = 1'b1;
				byte_count_d = cnt_inc;
				if (cnt_inc >= {8'd0, payload_len_q}) begin
					byte_count_d = '0;
					phase_d      = PH_FOOTER;
				end
			end
			PH_FOOTER: begin
				intag          = 1'b1;
				footer_value_d = {footer_value_q[23:0], b};
				if (byte_count_q >= flvtd_pkg::SIZE_LEN - 32'd1) begin
					last         = 1'b1;
					byte_count_d = '0;
					if (footer_value_d != flvtd_pkg::TAG_HDR_LEN + {8'd0, payload_len_q}) begin
						fatal      = 1'b1;
						err_code_d = flvtd_pkg::ST_FOOTER;
					end else begin
						phase_d  = PH_TAG_HDR;
						boundary = 1'b1;
					end
				end else begin
					byte_count_d = cnt_inc;
				end
			end
			default: begin
				fatal      = 1'b1;
				err_code_d = flvtd_pkg::ST_TRUNCATED;
			end
		endcase

		if (phase_q != PH_HALT && in_data.stream_end && !fatal && !boundary) begin
			fatal      = 1'b1;
			err_code_d = flvtd_pkg::ST_TRUNCATED;
		end
		if (fatal)
			phase_d = PH_HALT;

		// clean end on a section boundary: next byte starts a new stream
		restart = in_data.stream_end && boundary;

		out_d.out_byte      = b;
		out_d.in_tag        = intag;
		out_d.tag_first     = first;
		out_d.tag_last      = last;
		out_d.tag_type      = tag_kind_d;
		out_d.payload_size  = payload_len_d;
		out_d.tag_timestamp = tag_time_d;
		out_d.warning       = warn;
		out_d.status        = err_code_d;
		out_d.halted        = (phase_d == PH_HALT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_FILE_HDR;
			byte_count_q   <= '0;
			data_offset_q  <= '0;
			payload_len_q  <= '0;
			footer_value_q <= '0;
			tag_kind_q     <= '0;
			tag_time_q     <= '0;
			err_code_q     <= flvtd_pkg::ST_OK;
		end else if (accept) begin
			if (restart) begin
				phase_q        <= PH_FILE_HDR;
				byte_count_q   <= '0;
				data_offset_q  <= '0;
				payload_len_q  <= '0;
				footer_value_q <= '0;
				tag_kind_q     <= '0;
				tag_time_q     <= '0;
				err_code_q     <= flvtd_pkg::ST_OK;
			end else begin
				phase_q        <= phase_d;
				byte_count_q   <= byte_count_d;
				data_offset_q  <= data_offset_d;
				payload_len_q  <= payload_len_d;
				footer_value_q <= footer_value_d;
				tag_kind_q     <= tag_kind_d;
				tag_time_q     <= tag_time_d;
				err_code_q     <= err_code_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_q <= out_d;
	end

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HALT |=> phase_q == PH_HALT)
		else $error("framing left the halted state without reset");

	a_halt_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.halted |-> out_q.status != flvtd_pkg::ST_OK)
		else $error("halted result carries ok status");

	a_marks_in_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.tag_first || out_q.tag_last) |-> out_q.in_tag)
		else $error("tag mark outside a tag");

	a_warn_outside_tag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.warning != flvtd_pkg::WARN_NONE |-> !out_q.in_tag)
		else $error("warning raised on a tag byte");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("stalled result lost or changed");

endmodule

// ===== tb/tb_flv_tag_deframer.sv =====
// Testbench for the FLV tag deframer: byte streams checked against a built-in parser model.
`timescale 1ns / 100ps

module tb_flv_tag_deframer;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_SKIP,
		PH_FIRST_SIZE,
		PH_TAG_HDR,
		PH_PAYLOAD,
		PH_FOOTER,
		PH_HALT
	} parse_phase_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	flvtd_pkg::flv_in_t  in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	flvtd_pkg::flv_out_t out_data;

	// parser model state
	parse_phase_t m_phase;
	logic [31:0]  m_count;
	logic [31:0]  m_offset;
	logic [31:0]  m_shift;
	logic [23:0]  m_len;
	logic [7:0]   m_type;
	logic [31:0]  m_time;
	logic         m_stopped;
	logic [2:0]   m_code;

	flvtd_pkg::flv_out_t pending_results[$];
	logic [7:0]  stream_q[$];
	int unsigned err_count = 0;
	int unsigned bytes_sent = 0;
	int unsigned hold_cnt = 0;
	logic        tx_steady = 1'b0;
	logic        rx_steady = 1'b0;

	flv_tag_deframer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned rand_gap();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 6)
			return 0;
		else if (pick < 9)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic void clear_parser();
		m_phase   = PH_HEADER;
		m_count   = '0;
		m_offset  = '0;
		m_shift   = '0;
		m_len     = '0;
		m_type    = '0;
		m_time    = '0;
		m_stopped = 1'b0;
		m_code    = flvtd_pkg::ST_OK;
	endfunction

	function automatic void stop_framing(input logic [2:0] code);
		m_stopped = 1'b1;
		m_code    = code;
		m_phase   = PH_HALT;
	endfunction

	function automatic flvtd_pkg::flv_out_t deframe_byte(input flvtd_pkg::flv_in_t d);
		flvtd_pkg::flv_out_t r;
		logic [7:0] b;
		logic       boundary;
		logic       fatal;
		b = d.data_byte;
		r = '0;
		boundary = 1'b0;
		fatal = 1'b0;
		if (!m_stopped) begin
			case (m_phase)
			PH_HEADER: begin
				if (m_count < 4) begin
					m_shift = {m_shift[23:0], b};
					if (m_count == 3 && m_shift != flvtd_pkg::SIGNATURE) begin
						stop_framing(flvtd_pkg::ST_BAD_SIG);
						fatal = 1'b1;
					end
				end else if (m_count == 4) begin
					if ((b & flvtd_pkg::AV_MASK) == 8'h00)
						r.warning = flvtd_pkg::WARN_NO_AV;
				end else begin
					m_offset = {m_offset[23:0], b};
				end
				if (!fatal) begin
					if (m_count >= flvtd_pkg::FILE_HDR_LEN - 1) begin
						m_count = '0;
						if (m_offset < flvtd_pkg::FILE_HDR_LEN) begin
							stop_framing(flvtd_pkg::ST_LOW_OFFS);
							fatal = 1'b1;
						end else begin
							if (m_offset != flvtd_pkg::FILE_HDR_LEN)
								r.warning = flvtd_pkg::WARN_OFFSET;
							m_phase = (m_offset > flvtd_pkg::FILE_HDR_LEN) ?
								PH_SKIP : PH_FIRST_SIZE;
						end
					end else begin
						m_count++;
					end
				end
			end
			PH_SKIP: begin
				m_count++;
				if (m_count >= m_offset - flvtd_pkg::FILE_HDR_LEN) begin
					m_count = '0;
					m_phase = PH_FIRST_SIZE;
				end
			end
			PH_FIRST_SIZE: begin
				m_shift = {m_shift[23:0], b};
				if (m_count >= flvtd_pkg::SIZE_LEN - 1) begin
					if (m_shift != 32'd0)
						r.warning = flvtd_pkg::WARN_FIRST_SZ;
					m_count = '0;
					m_phase = PH_TAG_HDR;
					boundary = 1'b1;
				end else begin
					m_count++;
				end
			end
			PH_TAG_HDR: begin
				r.in_tag = 1'b1;
				if (m_count == 0) begin
					r.tag_first = 1'b1;
					m_type = b;
					m_len  = '0;
					m_time = '0;
				end else if (m_count <= 3) begin
					m_len = {m_len[15:0], b};
				end else if (m_count <= 6) begin
					// low 24 bits shift in, high byte kept
					m_time = {m_time[31:24], m_time[15:0], b};
				end else if (m_count == 7) begin
					m_time[31:24] = b;
				end
				if (m_count >= flvtd_pkg::TAG_HDR_LEN - 1) begin
					m_count = '0;
					m_phase = (m_len != 24'd0) ? PH_PAYLOAD : PH_FOOTER;
				end else begin
					m_count++;
				end
			end
			PH_PAYLOAD: begin
				r.in_tag = 1'b1;
				m_count++;
				if (m_count >= {8'd0, m_len}) begin
					m_count = '0;
					m_phase = PH_FOOTER;
				end
			end
			PH_FOOTER: begin
				r.in_tag = 1'b1;
				m_shift = {m_shift[23:0], b};
				if (m_count >= flvtd_pkg::SIZE_LEN - 1) begin
					r.tag_last = 1'b1;
					m_count = '0;
					if (m_shift != flvtd_pkg::TAG_HDR_LEN + {8'd0, m_len}) begin
						stop_framing(flvtd_pkg::ST_FOOTER);
						fatal = 1'b1;
					end else begin
						m_phase = PH_TAG_HDR;
						boundary = 1'b1;
					end
				end else begin
					m_count++;
				end
			end
			default: begin
				stop_framing(flvtd_pkg::ST_TRUNCATED);
				fatal = 1'b1;
			end
			endcase
			if (d.stream_end && !fatal && !boundary)
				stop_framing(flvtd_pkg::ST_TRUNCATED);
		end
		r.out_byte      = b;
		r.tag_type      = m_type;
		r.payload_size  = m_len;
		r.tag_timestamp = m_time;
		r.status        = m_code;
		r.halted        = m_stopped;
		// clean end of stream: ready for a new file header
		if (d.stream_end && boundary && !m_stopped)
			clear_parser();
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ERROR %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	task automatic compare_result(input flvtd_pkg::flv_out_t got,
			input flvtd_pkg::flv_out_t want);
		if (got.out_byte !== want.out_byte)
			report_mismatch("out_byte", 32'(got.out_byte), 32'(want.out_byte));
		if (got.in_tag !== want.in_tag)
			report_mismatch("in_tag", 32'(got.in_tag), 32'(want.in_tag));
		if (got.tag_first !== want.tag_first)
			report_mismatch("tag_first", 32'(got.tag_first), 32'(want.tag_first));
		if (got.tag_last !== want.tag_last)
			report_mismatch("tag_last", 32'(got.tag_last), 32'(want.tag_last));
		if (got.tag_type !== want.tag_type)
			report_mismatch("tag_type", 32'(got.tag_type), 32'(want.tag_type));
		if (got.payload_size !== want.payload_size)
			report_mismatch("payload_size", 32'(got.payload_size), 32'(want.payload_size));
		if (got.tag_timestamp !== want.tag_timestamp)
			report_mismatch("tag_timestamp", got.tag_timestamp, want.tag_timestamp);
		if (got.warning !== want.warning)
			report_mismatch("warning", 32'(got.warning), 32'(want.warning));
		if (got.status !== want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.halted !== want.halted)
			report_mismatch("halted", 32'(got.halted), 32'(want.halted));
	endtask

	// receiver stalls
	always @(posedge clk) begin
		if (hold_cnt != 0) begin
			hold_cnt <= hold_cnt - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
			if (!rx_steady && $urandom_range(0, 3) == 0)
				hold_cnt <= rand_gap();
		end
	end

	// result check first, then prediction of the byte taken at this edge
	always @(posedge clk) begin
		flvtd_pkg::flv_out_t want;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(out_data.out_byte),
					32'd0);
			end else begin
				want = pending_results.pop_front();
				compare_result(out_data, want);
			end
		end
		if (in_valid && in_ready)
			pending_results.push_back(deframe_byte(in_data));
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		gap = tx_steady ? 0 : rand_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{data_byte: b, stream_end: last};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// sends the built stream; stream_end is raised on byte end_at (none if negative)
	task automatic send_stream(input int end_at);
		for (int i = 0; i < stream_q.size(); i++)
			send_byte(stream_q[i], i == end_at);
		stream_q.delete();
	endtask

	task automatic add_word(input logic [31:0] w);
		stream_q.push_back(w[31:24]);
		stream_q.push_back(w[23:16]);
		stream_q.push_back(w[15:8]);
		stream_q.push_back(w[7:0]);
	endtask

	task automatic add_file_header(input logic [7:0] flags, input logic [31:0] offset,
			input logic [31:0] first_size);
		add_word(flvtd_pkg::SIGNATURE);
		stream_q.push_back(flags);
		add_word(offset);
		if (offset > flvtd_pkg::FILE_HDR_LEN)
			repeat (offset - flvtd_pkg::FILE_HDR_LEN)
				stream_q.push_back(8'($urandom_range(0, 255)));
		add_word(first_size);
	endtask

	task automatic add_tag_header(input logic [7:0] kind, input logic [23:0] len,
			input logic [31:0] stamp, input logic [23:0] stream_id);
		stream_q.push_back(kind);
		stream_q.push_back(len[23:16]);
		stream_q.push_back(len[15:8]);
		stream_q.push_back(len[7:0]);
		stream_q.push_back(stamp[23:16]);
		stream_q.push_back(stamp[15:8]);
		stream_q.push_back(stamp[7:0]);
		stream_q.push_back(stamp[31:24]);
		stream_q.push_back(stream_id[23:16]);
		stream_q.push_back(stream_id[15:8]);
		stream_q.push_back(stream_id[7:0]);
	endtask

	task automatic add_tag(input logic [7:0] kind, input logic [23:0] len,
			input logic [31:0] stamp, input logic [23:0] stream_id, input logic [31:0] footer);
		add_tag_header(kind, len, stamp, stream_id);
		repeat (len)
			stream_q.push_back(8'($urandom_range(0, 255)));
		add_word(footer);
	endtask

	// footer_flip nonzero corrupts the footer
	task automatic add_random_tag(input logic [31:0] footer_flip);
		int unsigned pick;
		logic [23:0] len;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			len = 24'($urandom_range(0, 8));
		else if (pick < 9)
			len = 24'($urandom_range(9, 40));
		else
			len = 24'($urandom_range(41, 120));
		add_tag(8'($urandom_range(0, 255)), len, $urandom, 24'($urandom),
			(flvtd_pkg::TAG_HDR_LEN + {8'd0, len}) ^ footer_flip);
	endtask

	task automatic add_random_file_header();
		int unsigned pick;
		logic [31:0] offs;
		pick = $urandom_range(0, 9);
		if (pick < 7)
			offs = flvtd_pkg::FILE_HDR_LEN;
		else if (pick < 9)
			offs = 32'($urandom_range(10, 16));
		else
			offs = 32'($urandom_range(17, 48));
		add_file_header(8'($urandom_range(0, 255)), offs,
			($urandom_range(0, 4) == 0) ? $urandom : 32'd0);
	endtask

	// every warning, a skipped byte, all-ones tag type, timestamp and stream id, clean end on a footer
	task automatic test_directed_stream();
		add_file_header(8'h00, flvtd_pkg::FILE_HDR_LEN + 1, 32'hFFFF_FFFF);
		add_tag(8'hFF, 24'd0, 32'hFFFF_FFFF, 24'hFF_FFFF, flvtd_pkg::TAG_HDR_LEN);
		send_stream(stream_q.size() - 1);
	endtask

	task automatic test_random_streams();
		int unsigned start;
		start = bytes_sent;
		while (bytes_sent - start < 260) begin
			tx_steady = ($urandom_range(0, 4) == 0);
			rx_steady = ($urandom_range(0, 4) == 0);
			add_random_file_header();
			repeat ($urandom_range(0, 4))
				add_random_tag(32'd0);
			// zero tags means the stream ends on the first size word
			send_stream(stream_q.size() - 1);
		end
	endtask

	// one fatal error per run, since only reset clears it; then halted echo
	task automatic test_fatal_error();
		int unsigned kind;
		int unsigned k;
		int end_at;
		int hdr_end;
		kind = $urandom_range(0, 3);
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		case (kind)
		0: begin
			add_file_header(8'($urandom_range(0, 255)), flvtd_pkg::FILE_HDR_LEN, 32'd0);
			k = $urandom_range(0, 3);
			stream_q[k] = stream_q[k] ^ 8'($urandom_range(1, 255));
			end_at = $urandom_range(0, 1) ? 3 : -1;
		end
		1: begin
			add_file_header(8'($urandom_range(0, 255)), 32'($urandom_range(0, 8)), $urandom);
			end_at = $urandom_range(0, 1) ? 8 : -1;
		end
		2: begin
			add_random_file_header();
			add_random_tag(32'd0);
			add_random_tag(32'h1 << $urandom_range(0, 31));
			end_at = $urandom_range(0, 1) ? stream_q.size() - 1 : -1;
		end
		default: begin
			add_file_header(8'($urandom_range(0, 255)), flvtd_pkg::FILE_HDR_LEN, 32'd0);
			hdr_end = stream_q.size() - 1;
			add_tag_header(8'($urandom_range(0, 255)), 24'($urandom_range(1, 24'hFF_FFFF)),
				$urandom, 24'($urandom));
			repeat (4)
				stream_q.push_back(8'($urandom_range(0, 255)));
			end_at = $urandom_range(0, stream_q.size() - 1);
			if (end_at == hdr_end)
				end_at++;
		end
		endcase
		send_stream(end_at);
		repeat (40)
			send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
	endtask

	initial begin
		clear_parser();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_stream();
		test_random_streams();
		test_fatal_error();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (err_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
